// ===== hw/rtl/model_image_parser_crc_assert.svh =====
// Assertion macros shared by the model image parser RTL.
`ifndef MODEL_IMAGE_PARSER_CRC_ASSERT_SVH
`define MODEL_IMAGE_PARSER_CRC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MIPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MIPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mipc_pkg.sv =====
// Types and constants shared by the model image parser modules.
package mipc_pkg;

    localparam logic [2:0] ITEM_MIN_N       = 3'd0;
    localparam logic [2:0] ITEM_MAX_N       = 3'd1;
    localparam logic [2:0] ITEM_FEATURE_DIM = 3'd2;
    localparam logic [2:0] ITEM_WCOUNT      = 3'd3;
    localparam logic [2:0] ITEM_WEIGHT      = 3'd4;
    localparam logic [2:0] ITEM_BIAS        = 3'd5;
    localparam logic [2:0] ITEM_STATUS      = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MAGIC   = 3'd1;
    localparam logic [2:0] ST_VERSION = 3'd2;
    localparam logic [2:0] ST_CRC     = 3'd3;
    localparam logic [2:0] ST_COUNT   = 3'd4;
    localparam logic [2:0] ST_TOOMANY = 3'd5;
    localparam logic [2:0] ST_TRUNC   = 3'd6;

    localparam logic [31:0] MAGIC_WORD  = 32'h0052_4C4C;
    localparam logic [31:0] IMG_VERSION = 32'd1;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    localparam logic [5:0] OFF_MAGIC_END = 6'd3;
    localparam logic [5:0] OFF_VER_END   = 6'd5;
    localparam logic [5:0] OFF_MIN_END   = 6'd13;
    localparam logic [5:0] OFF_MAX_END   = 6'd21;
    localparam logic [5:0] OFF_FDIM_END  = 6'd29;
    localparam logic [5:0] OFF_HDR_END   = 6'd33;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  item_type;
        logic [63:0] value;
        logic [15:0] weight_index;
        logic [2:0]  status;
        logic        last;
    } mipc_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mipc_q_status_t;

endpackage

// ===== hw/rtl/mipc_front.sv =====
// Parser front end: header and word assembly, CRC-32 and result generation.
module mipc_front #(
    parameter int MAX_WEIGHTS = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 start_req,
    output logic                 push,
    output mipc_pkg::mipc_item_t item
);
    import mipc_pkg::*;

    localparam int SW = $clog2(MAX_WEIGHTS + 1);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WEIGHTS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_WEIGHTS,
        PH_BIAS,
        PH_TRAILER,
        PH_DISCARD
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [5:0]      off_reg, off_next;
    logic [63:0]     asm_reg, asm_next;
    logic [31:0]     crc_reg, crc_next;
    logic [31:0]     wexp_reg, wexp_next;
    logic [SW-1:0]   wseen_reg, wseen_next;
    logic [63:0]     fdim_reg, fdim_next;

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    always_comb
    begin
        phase_t        ph_c;
        logic [5:0]    off_c;
        logic [63:0]   asm_c;
        logic [63:0]   asm_or;
        logic [31:0]   crc_c;
        logic [31:0]   wexp_c;
        logic [SW-1:0] wseen_c;
        logic [SW-1:0] wseen_inc;
        logic [63:0]   fdim_c;
        logic [2:0]    k;
        logic          active;
        logic [31:0]   v32;
        logic [31:0]   idx32;

        phase_next = phase_reg;
        off_next   = off_reg;
        asm_next   = asm_reg;
        crc_next   = crc_reg;
        wexp_next  = wexp_reg;
        wseen_next = wseen_reg;
        fdim_next  = fdim_reg;
        push       = 1'b0;
        item       = '0;

        ph_c    = phase_reg;
        off_c   = off_reg;
        asm_c   = asm_reg;
        crc_c   = crc_reg;
        wexp_c  = wexp_reg;
        wseen_c = wseen_reg;
        fdim_c  = fdim_reg;
        active  = 1'b0;
        k       = 3'd0;
        asm_or  = '0;
        v32     = '0;
        wseen_inc = '0;
        idx32   = 32'(wseen_reg);

        if (accept)
        begin
            if (start_req)
            begin
                if (phase_reg == PH_HEADER || phase_reg == PH_WEIGHTS ||
                    phase_reg == PH_BIAS || phase_reg == PH_TRAILER)
                begin
                    push           = 1'b1;
                    item.item_type = ITEM_STATUS;
                    item.status    = ST_TRUNC;
                    item.last      = 1'b1;
                end
                ph_c    = PH_HEADER;
                off_c   = '0;
                asm_c   = '0;
                crc_c   = '1;
                wexp_c  = '0;
                wseen_c = '0;
                fdim_c  = '0;
                active  = 1'b1;
            end
            else
            begin
                active = !(phase_reg == PH_IDLE || phase_reg == PH_DISCARD);
            end
        end

        if (active)
        begin
            phase_next = ph_c;
            off_next   = off_c;
            wexp_next  = wexp_c;
            wseen_next = wseen_c;
            fdim_next  = fdim_c;
            crc_next   = (ph_c != PH_TRAILER) ? crc_step(crc_c, data_byte) : crc_c;

            if (ph_c == PH_HEADER)
            begin
                if (off_c < 6'd4)
                    k = {1'b0, off_c[1:0]};
                else if (off_c < 6'd6)
                    k = 3'(off_c - 6'd4);
                else if (off_c < 6'd30)
                    k = 3'(off_c - 6'd6);
                else
                    k = {1'b0, 2'(off_c - 6'd30)};
            end
            else
            begin
                k = {1'b0, off_c[1:0]};
            end
            asm_or = asm_c | (64'(data_byte) << {k, 3'b000});
            asm_next = asm_or;

            if (ph_c == PH_HEADER)
            begin
                off_next = off_c + 6'd1;
                if (off_c == OFF_MAGIC_END)
                begin
                    asm_next = '0;
                    if (asm_or[31:0] != MAGIC_WORD)
                    begin
                        push           = 1'b1;
                        item.item_type = ITEM_STATUS;
                        item.status    = ST_MAGIC;
                        item.last      = 1'b1;
                        phase_next     = PH_DISCARD;
                    end
                end
                else if (off_c == OFF_VER_END)
                begin
                    asm_next = '0;
                    if (asm_or[31:0] != IMG_VERSION)
                    begin
                        push           = 1'b1;
                        item.item_type = ITEM_STATUS;
                        item.status    = ST_VERSION;
                        item.last      = 1'b1;
                        phase_next     = PH_DISCARD;
                    end
                end
                else if (off_c == OFF_MIN_END || off_c == OFF_MAX_END ||
                         off_c == OFF_FDIM_END)
                begin
                    asm_next = '0;
                    push     = 1'b1;
                    if (off_c == OFF_MIN_END)
                        item.item_type = ITEM_MIN_N;
                    else if (off_c == OFF_MAX_END)
                        item.item_type = ITEM_MAX_N;
                    else
                    begin
                        item.item_type = ITEM_FEATURE_DIM;
                        fdim_next      = asm_or;
                    end
                    item.value = asm_or;
                end
                else if (off_c >= OFF_HDR_END)
                begin
                    asm_next  = '0;
                    off_next  = '0;
                    wexp_next = asm_or[31:0];
                    push      = 1'b1;
                    if (asm_or[31:0] > MAX_W32)
                    begin
                        item.item_type = ITEM_STATUS;
                        item.status    = ST_TOOMANY;
                        item.last      = 1'b1;
                        phase_next     = PH_DISCARD;
                    end
                    else
                    begin
                        item.item_type = ITEM_WCOUNT;
                        item.value     = {32'd0, asm_or[31:0]};
                        phase_next     = (asm_or[31:0] == 32'd0) ? PH_BIAS : PH_WEIGHTS;
                    end
                end
            end
            else if (k[1:0] != 2'd3)
            begin
                off_next = {4'd0, k[1:0]} + 6'd1;
            end
            else
            begin
                asm_next = '0;
                off_next = '0;
                v32      = asm_or[31:0];
                push     = 1'b1;
                unique case (ph_c)
                    PH_WEIGHTS:
                    begin
                        idx32             = 32'(wseen_c);
                        wseen_inc         = wseen_c + SW'(1);
                        wseen_next        = wseen_inc;
                        item.item_type    = ITEM_WEIGHT;
                        item.value        = {32'd0, v32};
                        item.weight_index = idx32[15:0];
                        if (32'(wseen_inc) >= wexp_c)
                            phase_next = PH_BIAS;
                    end
                    PH_BIAS:
                    begin
                        item.item_type = ITEM_BIAS;
                        item.value     = {32'd0, v32};
                        phase_next     = PH_TRAILER;
                    end
                    default:
                    begin
                        item.item_type = ITEM_STATUS;
                        item.last      = 1'b1;
                        if (v32 != ~crc_c)
                            item.status = ST_CRC;
                        else if ({32'd0, wexp_c} != fdim_c)
                            item.status = ST_COUNT;
                        else
                            item.status = ST_OK;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            off_reg   <= '0;
            asm_reg   <= '0;
            crc_reg   <= '1;
            wexp_reg  <= '0;
            wseen_reg <= '0;
            fdim_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            asm_reg   <= asm_next;
            crc_reg   <= crc_next;
            wexp_reg  <= wexp_next;
            wseen_reg <= wseen_next;
            fdim_reg  <= fdim_next;
        end
    end

endmodule

// ===== hw/rtl/mipc_fifo.sv =====
// Short result queue between the parser front end and the output stage.
module mipc_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mipc_pkg::mipc_item_t     push_item,
    input  logic                     pop,
    output mipc_pkg::mipc_item_t     pop_item,
    output mipc_pkg::mipc_q_status_t stat
);
    import mipc_pkg::*;

    mipc_item_t      mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + Q_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - Q_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/mipc_back.sv =====
// Output stage: registers queued results onto the master stream.
module mipc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mipc_pkg::mipc_q_status_t q_stat,
    input  mipc_pkg::mipc_item_t     q_item,
    output logic                     pop,
    input  logic                     m_axis_tready,
    output logic                     m_axis_tvalid,
    // value[63:0], weight_index[79:64], status[82:80], zero fill[87:83]
    output logic [87:0]              m_axis_tdata,
    // item_type[2:0]
    output logic [2:0]               m_axis_tuser,
    output logic                     m_axis_tlast
);
    import mipc_pkg::*;

    logic       valid_reg, valid_next;
    mipc_item_t item_reg;

    assign pop        = !q_stat.empty && (!valid_reg || m_axis_tready);
    assign valid_next = pop ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= q_item;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {5'd0, item_reg.status, item_reg.weight_index, item_reg.value};
    assign m_axis_tuser  = item_reg.item_type;
    assign m_axis_tlast  = item_reg.last;

endmodule

// ===== hw/rtl/model_image_parser_crc.sv =====
// Top level of the streaming model image parser with CRC-32 check.
//
// The block takes one image byte per cycle and gives at most one result per byte, so it
// sustains one byte per clock for as long as the consumer takes results; the rate is set
// by the byte step of the parser front end (field assembly plus an eight-bit CRC-32
// update, done combinationally for each byte). A result passes from the parser through
// a four-entry result queue and an output register to the master stream, and the input
// stalls only when that queue is full. A non-ok final status means that every word
// already delivered for that image must be dropped.
`include "model_image_parser_crc_assert.svh"

module model_image_parser_crc #(
    parameter int MAX_WEIGHTS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0]
    input  logic [7:0]  s_axis_tdata,
    // start_req[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // value[63:0], weight_index[79:64], status[82:80], zero fill[87:83]
    output logic [87:0] m_axis_tdata,
    // item_type[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import mipc_pkg::*;

    logic           accept;
    logic           push;
    logic           pop;
    mipc_item_t     push_item;
    mipc_item_t     pop_item;
    mipc_q_status_t q_stat;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mipc_front #(
        .MAX_WEIGHTS(MAX_WEIGHTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_axis_tdata),
        .start_req (s_axis_tuser[0]),
        .push      (push),
        .item      (push_item)
    );

    mipc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    mipc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_item        (pop_item),
        .pop           (pop),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `MIPC_ASSERT_SAME(a_last_is_status, m_axis_tvalid && m_axis_tlast, m_axis_tuser == ITEM_STATUS, "last result is not a status")
    `MIPC_ASSERT_SAME(a_data_status_ok, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[82:80] == ST_OK, "data result carries a nonzero status")
    `MIPC_ASSERT_SAME(a_no_push_when_full, q_stat.full, !s_axis_tready && !accept, "input accepted while result queue is full")
    `MIPC_ASSERT_NEXT(a_push_fills_queue, push && !pop, !q_stat.empty, "pushed result did not reach the queue")

endmodule
